>>> hdl/salc_pkg.sv
`default_nettype none

package salc_pkg;

  localparam int ADDR_W     = 64;
  localparam int STAMP_W    = 64;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam int SET_BITS_W   = 4;
  localparam int BLOCK_BITS_W = 6;
  localparam int WAYS_W       = 4;

  // Effective geometry widths cover the whole parameter range (16 set bits, 64 ways).
  localparam int EFF_SET_W = 5;
  localparam int EFF_WAY_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 4'd0;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef struct packed {
    logic [EFF_SET_W-1:0]    set_bits;
    logic [BLOCK_BITS_W-1:0] block_bits;
    logic [EFF_WAY_W-1:0]    ways;
  } geom_t;

endpackage

`default_nettype wire

>>> hdl/set_assoc_lru_cache_sim_top.sv
// Set-associative cache model with least-recently-used replacement.
// An access beat is taken on a rising edge where start is high and busy is low;
// address carries the byte address. Each beat yields exactly one result beat:
// done is high for one cycle with hit, miss, evict and the saturating running
// totals. The receiver cannot stall, so results must be taken when done is high.
// The configuration port writes set_bits, block_bits and ways_in_use by index
// with cfg_write; writes are to be made only while the block is idle, and
// the block itself does not enforce this. Each set is one row of a single
// synchronous RAM, read when the beat is taken, scanned one way per cycle and
// written back once. With W the ways in use (ways_in_use held to the range 1
// to MAX_WAYS), the scan stops at the way that hits, or after way W-1 on a
// miss; the row is then written back as done is registered. busy falls in
// the cycle that done is high, so the next beat can be taken then; a new beat
// is not taken while one is still in flight.
// After reset the block clears every row, one per cycle, holding busy high
// until all 2**MAX_SET_BITS rows are clear; totals, the access clock and
// configuration return to their reset values at once.
`default_nettype none

module set_assoc_lru_cache_sim_top
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [ADDR_W-1:0]     address,
  output logic                       done,
  output logic                       hit,
  output logic                       miss,
  output logic                       evict,
  output logic [TOTAL_W-1:0]         hit_total,
  output logic [TOTAL_W-1:0]         miss_total,
  output logic [TOTAL_W-1:0]         evict_total,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = 1 << MAX_SET_BITS;
  localparam int SET_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W = MAX_WAYS * $bits(line_t);

  geom_t            geom;
  logic             ram_wr_en;
  logic [SET_W-1:0] ram_wr_addr;
  logic [ROW_W-1:0] ram_wr_data;
  logic             ram_rd_en;
  logic [SET_W-1:0] ram_rd_addr;
  logic [ROW_W-1:0] ram_rd_data;

  salc_cfg #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  salc_ctrl #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .address     (address),
    .geom        (geom),
    .done        (done),
    .hit         (hit),
    .miss        (miss),
    .evict       (evict),
    .hit_total   (hit_total),
    .miss_total  (miss_total),
    .evict_total (evict_total),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

endmodule

`default_nettype wire

>>> hdl/salc_ram.sv
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/salc_cfg.sv
`default_nettype none

module salc_cfg
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output geom_t                      geom
);

  logic [SET_BITS_W-1:0]   set_bits;
  logic [BLOCK_BITS_W-1:0] block_bits;
  logic [WAYS_W-1:0]       ways_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= SET_BITS_RST;
      block_bits  <= BLOCK_BITS_RST;
      ways_in_use <= WAYS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SET_BITS:    set_bits    <= cfg_data[SET_BITS_W-1:0];
        REG_BLOCK_BITS:  block_bits  <= cfg_data[BLOCK_BITS_W-1:0];
        REG_WAYS_IN_USE: ways_in_use <= cfg_data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range set_bits and ways_in_use are clamped to what the store holds; zero ways counts as one.
  always_comb begin
    if (EFF_SET_W'(set_bits) > EFF_SET_W'(MAX_SET_BITS)) begin
      geom.set_bits = EFF_SET_W'(MAX_SET_BITS);
    end else begin
      geom.set_bits = EFF_SET_W'(set_bits);
    end
    geom.block_bits = block_bits;
    if (ways_in_use == '0) begin
      geom.ways = EFF_WAY_W'(1);
    end else if (EFF_WAY_W'(ways_in_use) > EFF_WAY_W'(MAX_WAYS)) begin
      geom.ways = EFF_WAY_W'(MAX_WAYS);
    end else begin
      geom.ways = EFF_WAY_W'(ways_in_use);
    end
  end

endmodule

`default_nettype wire

>>> hdl/salc_ctrl.sv
`default_nettype none

module salc_ctrl
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  localparam int DEPTH = 1 << MAX_SET_BITS,
  localparam int SET_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int ROW_W = MAX_WAYS * $bits(line_t)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [ADDR_W-1:0]  address,
  input  wire geom_t              geom,
  output logic                    done,
  output logic                    hit,
  output logic                    miss,
  output logic                    evict,
  output logic [TOTAL_W-1:0]      hit_total,
  output logic [TOTAL_W-1:0]      miss_total,
  output logic [TOTAL_W-1:0]      evict_total,
  output logic                    ram_wr_en,
  output logic [SET_W-1:0]        ram_wr_addr,
  output logic [ROW_W-1:0]        ram_wr_data,
  output logic                    ram_rd_en,
  output logic [SET_W-1:0]        ram_rd_addr,
  input  wire logic [ROW_W-1:0]   ram_rd_data
);

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  typedef line_t [MAX_WAYS-1:0] row_t;

  logic [1:0]         state;
  logic [SET_W-1:0]   clear_addr;
  logic [SET_W-1:0]   set_idx;
  logic [ADDR_W-1:0]  tag;
  logic [STAMP_W-1:0] access_clock;
  logic [WAY_W-1:0]   way;
  logic               found;
  logic [WAY_W-1:0]   hit_way;
  logic               have_empty;
  logic [WAY_W-1:0]   empty_way;
  logic               have_victim;
  logic [WAY_W-1:0]   victim_way;
  logic [STAMP_W-1:0] best_stamp;

  logic               accept;
  logic [ADDR_W-1:0]  set_mask;
  logic [SET_W-1:0]   set_idx_next;
  logic [EFF_WAY_W:0] tag_shift;
  logic [ADDR_W-1:0]  tag_next;
  row_t               row;
  row_t               row_next;
  line_t              cur;
  logic               cur_match;
  logic               last_way;
  logic [WAY_W-1:0]   target;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // The address is split combinationally, so the set index addresses the row read as the beat is taken.
  always_comb begin
    set_mask     = (ADDR_W'(1) << geom.set_bits) - ADDR_W'(1);
    set_idx_next = SET_W'((address >> geom.block_bits) & set_mask);
    tag_shift    = (EFF_WAY_W + 1)'(geom.block_bits) + (EFF_WAY_W + 1)'(geom.set_bits);
    if (tag_shift >= (EFF_WAY_W + 1)'(ADDR_W)) begin
      tag_next = '0;
    end else begin
      tag_next = address >> tag_shift;
    end
  end

  assign row       = row_t'(ram_rd_data);
  assign cur       = row[way];
  assign cur_match = cur.valid && (cur.tag == tag);
  assign last_way  = (EFF_WAY_W'(way) + EFF_WAY_W'(1)) == geom.ways;

  always_comb begin
    if (found) begin
      target = hit_way;
    end else if (have_empty) begin
      target = empty_way;
    end else begin
      target = victim_way;
    end
    row_next               = row;
    row_next[target].valid = 1'b1;
    row_next[target].tag   = tag;
    row_next[target].stamp = access_clock;
  end

  always_comb begin
    ram_rd_en   = accept;
    ram_rd_addr = set_idx_next;
    ram_wr_en   = (state == ST_CLEAR) || (state == ST_UPDATE);
    if (state == ST_CLEAR) begin
      ram_wr_addr = clear_addr;
      ram_wr_data = '0;
    end else begin
      ram_wr_addr = set_idx;
      ram_wr_data = ROW_W'(row_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clear_addr   <= '0;
      access_clock <= '0;
      done         <= 1'b0;
      hit_total    <= '0;
      miss_total   <= '0;
      evict_total  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + SET_W'(1);
          if (clear_addr == SET_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            access_clock <= access_clock + STAMP_W'(1);
            state        <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cur_match || last_way) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (found) begin
            if (hit_total != '1) begin
              hit_total <= hit_total + TOTAL_W'(1);
            end
          end else begin
            if (miss_total != '1) begin
              miss_total <= miss_total + TOTAL_W'(1);
            end
            if (!have_empty && evict_total != '1) begin
              evict_total <= evict_total + TOTAL_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_idx     <= set_idx_next;
      tag         <= tag_next;
      way         <= '0;
      found       <= 1'b0;
      hit_way     <= '0;
      have_empty  <= 1'b0;
      empty_way   <= '0;
      have_victim <= 1'b0;
      victim_way  <= '0;
      best_stamp  <= '0;
    end else if (state == ST_SCAN) begin
      if (cur_match) begin
        found   <= 1'b1;
        hit_way <= way;
      end else begin
        if (cur.valid) begin
          if (!have_victim || cur.stamp < best_stamp) begin
            have_victim <= 1'b1;
            victim_way  <= way;
            best_stamp  <= cur.stamp;
          end
        end else if (!have_empty) begin
          have_empty <= 1'b1;
          empty_way  <= way;
        end
        if (!last_way) begin
          way <= way + WAY_W'(1);
        end
      end
    end
    if (state == ST_UPDATE) begin
      hit   <= found;
      miss  <= !found;
      evict <= !found && !have_empty;
    end
  end

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot({hit, miss}))
    else $error("Result beat carries neither or both of hit and miss.");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    done && evict |-> miss)
    else $error("Eviction reported on a hit.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && state == ST_SCAN)
    else $error("Accepted beat did not start a set scan.");

  a_done_from_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_UPDATE && !busy)
    else $error("Result beat without a preceding row write-back.");

endmodule

`default_nettype wire

>>> dv/testbench.sv
module testbench;
  import salc_pkg::*;

  localparam int MAX_SET_BITS = 8;
  localparam int MAX_WAYS     = 8;
  localparam int LINE_COUNT   = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int RANDOM_ITEMS = 1000;
  localparam int MAX_GAP      = 12;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic               hit;
    logic               miss;
    logic               evict;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
    logic [TOTAL_W-1:0] evictions;
  } outcome_t;

  class cache_scoreboard;
    bit                      present[LINE_COUNT];
    logic [ADDR_W-1:0]       tag_of[LINE_COUNT];
    logic [STAMP_W-1:0]      last_use[LINE_COUNT];
    logic [STAMP_W-1:0]      use_clock;
    logic [TOTAL_W-1:0]      hits;
    logic [TOTAL_W-1:0]      misses;
    logic [TOTAL_W-1:0]      evictions;
    logic [SET_BITS_W-1:0]   cfg_sets;
    logic [BLOCK_BITS_W-1:0] cfg_offset;
    logic [WAYS_W-1:0]       cfg_ways;
    outcome_t                outcome_q[$];
    int unsigned             fail_count;

    function new();
      foreach (present[i]) begin
        present[i]  = 1'b0;
        tag_of[i]   = '0;
        last_use[i] = '0;
      end
      use_clock  = '0;
      hits       = '0;
      misses     = '0;
      evictions  = '0;
      cfg_sets   = SET_BITS_RST;
      cfg_offset = BLOCK_BITS_RST;
      cfg_ways   = WAYS_RST;
      fail_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SET_BITS:    cfg_sets = data[SET_BITS_W-1:0];
        REG_BLOCK_BITS:  cfg_offset = data[BLOCK_BITS_W-1:0];
        REG_WAYS_IN_USE: cfg_ways = data[WAYS_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned set_width();
      return (cfg_sets > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_sets);
    endfunction

    function int unsigned way_count();
      if (cfg_ways == 0) return 1;
      return (cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways);
    endfunction

    function logic [TOTAL_W-1:0] bump(logic [TOTAL_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void note_access(logic [ADDR_W-1:0] addr);
      int unsigned       sw;
      int unsigned       ways;
      int unsigned       base;
      int unsigned       slot;
      int                found;
      int                empty;
      int                victim;
      logic [ADDR_W-1:0] set_idx;
      logic [ADDR_W-1:0] tag;
      logic [STAMP_W-1:0] oldest;
      outcome_t          o;
      sw     = set_width();
      ways   = way_count();
      found  = -1;
      empty  = -1;
      victim = -1;
      oldest = '0;
      o      = '0;
      use_clock = use_clock + 1'b1;
      set_idx = (addr >> cfg_offset) & ((64'd1 << sw) - 64'd1);
      tag = (int'(cfg_offset) + sw >= ADDR_W) ? '0 : addr >> (int'(cfg_offset) + sw);
      base = int'(set_idx[MAX_SET_BITS-1:0]) * MAX_WAYS;
      for (int w = 0; w < ways; w++) begin
        if (present[base + w]) begin
          if (tag_of[base + w] == tag) begin
            found = w;
            break;
          end
          if (victim < 0 || last_use[base + w] < oldest) begin
            oldest = last_use[base + w];
            victim = w;
          end
        end else if (empty < 0) begin
          empty = w;
        end
      end
      if (found >= 0) begin
        o.hit = 1'b1;
        hits = bump(hits);
        last_use[base + found] = use_clock;
      end else begin
        o.miss = 1'b1;
        misses = bump(misses);
        if (empty >= 0) begin
          slot = base + empty;
        end else begin
          o.evict = 1'b1;
          evictions = bump(evictions);
          slot = base + ((victim < 0) ? 0 : victim);
        end
        present[slot]  = 1'b1;
        tag_of[slot]   = tag;
        last_use[slot] = use_clock;
      end
      o.hits      = hits;
      o.misses    = misses;
      o.evictions = evictions;
      outcome_q.push_back(o);
    endfunction

    function void flag(string msg);
      fail_count++;
      $error("%s", msg);
    endfunction

    function void compare_field(string name, logic [TOTAL_W-1:0] want,
                                logic [TOTAL_W-1:0] got);
      if (got !== want) flag($sformatf("%s: expected %0d, got %0d", name, want, got));
    endfunction

    function void check_outcome(logic h, logic m, logic e, logic [TOTAL_W-1:0] ht,
                                logic [TOTAL_W-1:0] mt, logic [TOTAL_W-1:0] et);
      outcome_t o;
      if (outcome_q.size() == 0) begin
        flag("result beat with no access outstanding");
        return;
      end
      o = outcome_q.pop_front();
      compare_field("hit", TOTAL_W'(o.hit), TOTAL_W'(h));
      compare_field("miss", TOTAL_W'(o.miss), TOTAL_W'(m));
      compare_field("evict", TOTAL_W'(o.evict), TOTAL_W'(e));
      compare_field("hit_total", o.hits, ht);
      compare_field("miss_total", o.misses, mt);
      compare_field("evict_total", o.evictions, et);
    endfunction

    function bit clean();
      if (outcome_q.size() != 0)
        flag($sformatf("%0d results never arrived", outcome_q.size()));
      return fail_count == 0;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [ADDR_W-1:0]     address;
  logic                  done;
  logic                  hit;
  logic                  miss;
  logic                  evict;
  logic [TOTAL_W-1:0]    hit_total;
  logic [TOTAL_W-1:0]    miss_total;
  logic [TOTAL_W-1:0]    evict_total;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cache_scoreboard cache_sb = new();
  int unsigned     sent;
  bit              burst;

  set_assoc_lru_cache_sim_top u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .address     (address),
    .done        (done),
    .hit         (hit),
    .miss        (miss),
    .evict       (evict),
    .hit_total   (hit_total),
    .miss_total  (miss_total),
    .evict_total (evict_total),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      cache_sb.check_outcome(hit, miss, evict, hit_total, miss_total, evict_total);
    end
  end

  function automatic logic [ADDR_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] make_addr(logic [ADDR_W-1:0] tag,
                                                   int unsigned set_idx,
                                                   logic [ADDR_W-1:0] offset);
    int unsigned       sw;
    int unsigned       bw;
    logic [ADDR_W-1:0] upper;
    sw = cache_sb.set_width();
    bw = 32'(cache_sb.cfg_offset);
    upper = (bw + sw >= ADDR_W) ? '0 : tag << (bw + sw);
    return upper | ((64'(set_idx) & ((64'd1 << sw) - 64'd1)) << bw)
         | (offset & ((64'd1 << bw) - 64'd1));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] tag;
    int unsigned       set_idx;
    if ($urandom_range(0, 9) == 0) return rand_word();
    tag = ADDR_W'($urandom_range(0, cache_sb.way_count() + 2));
    if ($urandom_range(0, 3) == 0) set_idx = $urandom_range(0, 255);
    else set_idx = $urandom_range(0, 3);
    return make_addr(tag, set_idx, rand_word());
  endfunction

  task automatic send_access(input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    address <= addr;
    do @(posedge clk); while (busy !== 1'b0);
    cache_sb.note_access(addr);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (cache_sb.outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cache_sb.write_reg(idx, data);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] sets,
                              input logic [CFG_DATA_W-1:0] offset,
                              input logic [CFG_DATA_W-1:0] ways);
    drain();
    write_reg(REG_SET_BITS, sets);
    write_reg(REG_BLOCK_BITS, offset);
    write_reg(REG_WAYS_IN_USE, ways);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v);
    if ($urandom_range(0, 3) == 0) v[5:4] = 2'($urandom_range(1, 3));
    return v;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] s;
    logic [CFG_DATA_W-1:0] b;
    logic [CFG_DATA_W-1:0] w;
    int unsigned           n;
    rst       <= 1'b1;
    start     <= 1'b0;
    address   <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    sent  = 0;
    burst = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (busy !== 1'b0);

    // Reset geometry: one set, sixteen-byte blocks, one way.
    send_access('0);
    send_access(64'hF);
    send_access('1);
    send_access(64'h10);
    send_access(64'h1F);

    drain();
    write_reg(REG_SPARE, 6'h2A);
    set_geometry(6'd2, 6'd4, 6'd4);
    for (int t = 1; t <= 4; t++) send_access(make_addr(ADDR_W'(t), 1, rand_word()));
    send_access(make_addr(1, 1, '0));
    send_access(make_addr(5, 1, '0));
    send_access(make_addr(2, 1, '0));

    // Fewer ways: lines left in the upper ways must stay out of play.
    set_geometry(6'd2, 6'd4, 6'd2);
    send_access(make_addr(4, 1, '0));
    send_access(make_addr(1, 1, '0));

    set_geometry(6'h3C, 6'd0, 6'd0);
    send_access(make_addr(7, 255, '0));
    send_access(make_addr(7, 255, '0));
    send_access(make_addr(8, 255, '0));

    // Offset and index cover the whole address, so every tag is zero.
    set_geometry(6'd8, 6'd60, 6'd15);
    send_access(64'hA000_0000_0000_0000);
    send_access(64'hA123_4567_89AB_CDEF);
    send_access(64'h5FFF_FFFF_FFFF_FFFF);
    set_geometry(6'd8, 6'd63, 6'd8);
    send_access(64'h8000_0000_0000_0000);
    send_access(64'h7FFF_FFFF_FFFF_FFFF);

    while (sent < RANDOM_ITEMS + 22) begin
      case ($urandom_range(0, 4))
        0: s = 0;
        1: s = MAX_SET_BITS;
        2: s = CFG_DATA_W'($urandom_range(MAX_SET_BITS + 1, 15));
        default: s = CFG_DATA_W'($urandom_range(0, MAX_SET_BITS));
      endcase
      case ($urandom_range(0, 5))
        0: b = 0;
        1: b = 32;
        2: b = 63;
        3: b = CFG_DATA_W'($urandom_range(33, 63));
        default: b = CFG_DATA_W'($urandom_range(0, 32));
      endcase
      case ($urandom_range(0, 5))
        0: w = 0;
        1: w = 1;
        2: w = MAX_WAYS;
        3: w = CFG_DATA_W'($urandom_range(MAX_WAYS + 1, 15));
        default: w = CFG_DATA_W'($urandom_range(1, MAX_WAYS));
      endcase
      burst = 1'b0;
      set_geometry(with_junk(s), b, with_junk(w));
      burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 160);
      repeat (n) send_access(pick_address());
    end

    drain();
    repeat (MAX_WAYS + 4) @(posedge clk);
    if (cache_sb.clean()) begin
      $display("set_assoc_lru_cache_sim_top verification clean");
    end else begin
      $display("set_assoc_lru_cache_sim_top verification failed");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("set_assoc_lru_cache_sim_top verification failed");
    $finish;
  end

endmodule
